/* rtl/distance_alpha_fade_macros.svh */
// Assertion helpers for the top-level RTL file.
`ifndef DISTANCE_ALPHA_FADE_MACROS_SVH
`define DISTANCE_ALPHA_FADE_MACROS_SVH

// Flag a condition that must never hold out of reset.
`define DAF_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("daf: forbidden condition");

// Flag a broken implication out of reset.
`define DAF_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("daf: implication failed");

`endif

/* rtl/daf_pkg.sv */
`default_nettype none
package daf_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FADE_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_END   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ALPHA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_ALPHA  = 3'd3;

    localparam int unsigned ROOT_W = 16;

    typedef enum logic [1:0] {
        CLS_START = 2'd0,
        CLS_END   = 2'd1,
        CLS_MID   = 2'd2
    } t_cls;

    typedef struct packed {
        logic [15:0] fade_start;
        logic [15:0] fade_end;
        logic [15:0] start_alpha;
        logic [15:0] end_alpha;
    } t_cfg;

    typedef struct packed {
        logic [15:0] idx;
        logic [31:0] sq;
        t_cls        cls;
    } t_item;

endpackage
`default_nettype wire

/* rtl/daf_front.sv */
`default_nettype none
module daf_front
    import daf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [15:0] i_idx,
    input  wire logic [15:0] i_x,
    input  wire logic [15:0] i_y,
    input  wire logic [15:0] i_z,
    input  wire t_cfg        i_cfg,
    output logic             o_push,
    output t_item            o_item
);

    logic        r_v1, r_v2, r_v3;
    logic [15:0] r_idx1, r_idx2;
    logic [31:0] r_xx, r_yy, r_zz;
    logic [31:0] r_sum;
    logic [31:0] r_ssq, r_esq;
    t_item       r_item;
    t_cls        n_cls;

    // squared thresholds, refreshed every cycle
    always_ff @(posedge i_clk) begin
        r_ssq <= 32'(i_cfg.fade_start * i_cfg.fade_start);
        r_esq <= 32'(i_cfg.fade_end * i_cfg.fade_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_comb begin
        if (r_sum < r_ssq) begin
            n_cls = CLS_START;
        end else if (r_sum >= r_esq) begin
            n_cls = CLS_END;
        end else begin
            n_cls = CLS_MID;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= i_idx;
        r_xx   <= 32'($signed(i_x) * $signed(i_x));
        r_yy   <= 32'($signed(i_y) * $signed(i_y));
        r_zz   <= 32'($signed(i_z) * $signed(i_z));
        r_idx2 <= r_idx1;
        r_sum  <= r_xx + r_yy + r_zz;
        r_item.idx <= r_idx2;
        r_item.sq  <= r_sum;
        r_item.cls <= n_cls;
    end

    assign o_push = r_v3;
    assign o_item = r_item;

endmodule
`default_nettype wire

/* rtl/daf_queue.sv */
`default_nettype none
module daf_queue
    import daf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output logic       o_nonempty,
    output logic       o_full,
    output t_item      o_item,
    output logic [1:0] o_count
);

    t_item       r_mem [0:1];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        do_push, do_pop;

    assign do_pop  = i_pop && (r_cnt != 2'd0);
    assign do_push = i_push && ((r_cnt != 2'd2) || do_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_item;
    end

    assign o_item     = r_mem[r_rp];
    assign o_nonempty = (r_cnt != 2'd0);
    assign o_full     = (r_cnt == 2'd2);
    assign o_count    = r_cnt;

endmodule
`default_nettype wire

/* rtl/daf_back.sv */
`default_nettype none
module daf_back
    import daf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_item       i_item,
    input  wire t_cfg        i_cfg,
    output logic             o_strobe,
    output logic [15:0]      o_idx,
    output logic [15:0]      o_alpha
);

    // square root pipeline: two radicand bits per stage
    logic              r_sv   [0:ROOT_W];
    logic [19:0]       r_srem [0:ROOT_W];
    logic [15:0]       r_sroot[0:ROOT_W];
    logic [31:0]       r_ssq  [0:ROOT_W];
    logic [15:0]       r_sidx [0:ROOT_W];
    t_cls              r_scls [0:ROOT_W];

    // divider pipeline: one quotient bit per stage
    logic              r_dv   [0:16];
    logic [15:0]       r_drem [0:16];
    logic [15:0]       r_dq   [0:16];
    logic [15:0]       r_didx [0:16];
    t_cls              r_dcls [0:16];

    logic              r_mv, r_ov;
    logic [33:0]       r_prod;
    logic [15:0]       r_midx, r_oidx, r_oalpha;
    t_cls              r_mcls;
    logic [15:0]       span;

    assign span = i_cfg.fade_end - i_cfg.fade_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else begin
            r_sv[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_srem[0]  <= '0;
        r_sroot[0] <= '0;
        r_ssq[0]   <= i_item.sq;
        r_sidx[0]  <= i_item.idx;
        r_scls[0]  <= i_item.cls;
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        logic [19:0] cat, trial;
        assign cat   = {r_srem[k][17:0], r_ssq[k][31-2*k -: 2]};
        assign trial = {2'b00, r_sroot[k], 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else begin
                r_sv[k+1] <= r_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (cat >= trial) begin
                r_srem[k+1]  <= cat - trial;
                r_sroot[k+1] <= {r_sroot[k][14:0], 1'b1};
            end else begin
                r_srem[k+1]  <= cat;
                r_sroot[k+1] <= {r_sroot[k][14:0], 1'b0};
            end
            r_ssq[k+1]  <= r_ssq[k];
            r_sidx[k+1] <= r_sidx[k];
            r_scls[k+1] <= r_scls[k];
        end
    end

    // numerator of the fade fraction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= r_sv[ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_drem[0] <= r_sroot[ROOT_W] - i_cfg.fade_start;
        r_dq[0]   <= '0;
        r_didx[0] <= r_sidx[ROOT_W];
        r_dcls[0] <= r_scls[ROOT_W];
    end

    for (genvar j = 0; j < 16; j++) begin : g_div
        logic [16:0] sh;
        logic        ge;
        assign sh = {r_drem[j], 1'b0};
        assign ge = (sh >= {1'b0, span});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1] <= 1'b0;
            end else begin
                r_dv[j+1] <= r_dv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_drem[j+1] <= ge ? 16'(sh - {1'b0, span}) : sh[15:0];
            r_dq[j+1]   <= {r_dq[j][14:0], ge};
            r_didx[j+1] <= r_didx[j];
            r_dcls[j+1] <= r_dcls[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_mv <= r_dv[16];
            r_ov <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 34'(($signed({1'b0, i_cfg.end_alpha}) - $signed({1'b0, i_cfg.start_alpha}))
                  * $signed({1'b0, r_dq[16]}));
        r_midx <= r_didx[16];
        r_mcls <= r_dcls[16];
        r_oidx <= r_midx;
        case (r_mcls)
            CLS_START: r_oalpha <= i_cfg.start_alpha;
            CLS_END:   r_oalpha <= i_cfg.end_alpha;
            default:   r_oalpha <= i_cfg.start_alpha + r_prod[31:16];
        endcase
    end

    assign o_strobe = r_ov;
    assign o_idx    = r_oidx;
    assign o_alpha  = r_oalpha;

endmodule
`default_nettype wire

/* rtl/distance_alpha_fade.sv */
// distance_alpha_fade: fades a particle's alpha with its distance.
// Input channel: drive i_particle_index and i_disp_x/y/z (signed Q8.8) with
// start high; the word is taken at the rising edge where start is high and
// busy is low. One word can be taken every cycle while busy is low.
// Result channel: o_strobe is high for exactly one cycle with o_out_index and
// o_new_alpha (Q0.16). Results come out in input order, one per word; the
// receiver cannot stall the block.
// Throughput is one word per cycle: the front squares and classifies, a
// two-entry queue hands words to the back, where a 16-stage square root and
// a 16-stage divider, one bit per stage, then one multiply, do the work.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_idx
// (0 fade start, 1 fade end, 2 start alpha, 3 end alpha); other indexes are
// dropped. Write only while no word is in flight.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads the
// register defaults: start 0, end 65535, start alpha 65535, end alpha 0.
`default_nettype none
module distance_alpha_fade
    import daf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [15:0]          i_particle_index,
    input  wire logic [15:0]          i_disp_x,
    input  wire logic [15:0]          i_disp_y,
    input  wire logic [15:0]          i_disp_z,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [15:0]          i_cfg_wdata,
    output logic                      o_strobe,
    output logic [15:0]               o_out_index,
    output logic [15:0]               o_new_alpha
);

`include "distance_alpha_fade_macros.svh"

    t_cfg        r_cfg;
    logic        accept;
    logic        push, q_nonempty, q_full;
    logic [1:0]  q_count;
    t_item       f_item, q_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fade_start  <= 16'd0;
            r_cfg.fade_end    <= 16'hFFFF;
            r_cfg.start_alpha <= 16'hFFFF;
            r_cfg.end_alpha   <= 16'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FADE_START:  r_cfg.fade_start  <= i_cfg_wdata;
                CFG_FADE_END:    r_cfg.fade_end    <= i_cfg_wdata;
                CFG_START_ALPHA: r_cfg.start_alpha <= i_cfg_wdata;
                CFG_END_ALPHA:   r_cfg.end_alpha   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Hold off new words only if the queue is full; the back drains it
    // every cycle, so this stays low in practice.
    assign busy   = q_full;
    assign accept = start && !busy;

    daf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_idx   (i_particle_index),
        .i_x     (i_disp_x),
        .i_y     (i_disp_y),
        .i_z     (i_disp_z),
        .i_cfg   (r_cfg),
        .o_push  (push),
        .o_item  (f_item)
    );

    daf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (f_item),
        .i_pop      (q_nonempty),
        .o_nonempty (q_nonempty),
        .o_full     (q_full),
        .o_item     (q_item),
        .o_count    (q_count)
    );

    // The back never stalls: pop whenever a word waits.
    daf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_nonempty),
        .i_item   (q_item),
        .i_cfg    (r_cfg),
        .o_strobe (o_strobe),
        .o_idx    (o_out_index),
        .o_alpha  (o_new_alpha)
    );

    // The queue is drained each cycle, so it never holds more than one word.
    `DAF_NEVER(a_queue_depth, q_count > 2'd1)
    // A front push must always find room in the queue.
    `DAF_IMPLIES(a_no_overflow, push, !q_full)

endmodule
`default_nettype wire

/* tb/tb_alpha_checker.sv */
`timescale 1ns / 100ps
module tb_alpha_checker
    import daf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic [15:0]          i_particle_index,
    input  wire logic [15:0]          i_disp_x,
    input  wire logic [15:0]          i_disp_y,
    input  wire logic [15:0]          i_disp_z,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [15:0]          i_cfg_wdata,
    input  wire logic                 o_strobe,
    input  wire logic [15:0]          o_out_index,
    input  wire logic [15:0]          o_new_alpha,
    output int                        fail_count,
    output int                        pending_count
);

    typedef struct {
        logic [15:0] tag;
        logic [15:0] alpha;
    } t_fade_word;

    logic [15:0] fade_near;
    logic [15:0] fade_far;
    logic [15:0] alpha_near;
    logic [15:0] alpha_far;
    t_fade_word  alpha_queue[$];

    function automatic logic [31:0] floor_root(logic [31:0] v);
        logic [31:0] r;
        r = 0;
        for (int b = 15; b >= 0; b--) begin
            if (((r | (32'd1 << b)) * (r | (32'd1 << b))) <= v)
                r = r | (32'd1 << b);
        end
        return r;
    endfunction

    function automatic logic [15:0] faded_alpha(logic [15:0] dx, logic [15:0] dy,
                                                logic [15:0] dz);
        longint sx, sy, sz, sq, s, e, root_len, t, diff, prod, stp;
        sx = longint'($signed(dx));
        sy = longint'($signed(dy));
        sz = longint'($signed(dz));
        sq = sx * sx + sy * sy + sz * sz;
        s = fade_near;
        e = fade_far;
        if (sq < s * s) return alpha_near;
        if (sq >= e * e) return alpha_far;
        root_len = floor_root(sq[31:0]);
        t = ((root_len - s) << 16) / (e - s);
        diff = longint'(alpha_far) - longint'(alpha_near);
        prod = diff * t;
        // floor division: round negative steps toward minus infinity
        if (prod >= 0) stp = prod >>> 16;
        else stp = -((-prod + 65535) >>> 16);
        return 16'(longint'(alpha_near) + stp);
    endfunction

    assign pending_count = alpha_queue.size();

    always @(posedge i_clk) begin
        t_fade_word w;
        if (!i_rst_n) begin
            fade_near  <= 16'd0;
            fade_far   <= 16'hFFFF;
            alpha_near <= 16'hFFFF;
            alpha_far  <= 16'd0;
            alpha_queue.delete();
            fail_count <= 0;
        end else begin
            if (o_strobe) begin
                if (alpha_queue.size() == 0) begin
                    $display("%0t: unexpected word idx %h alpha %h", $time,
                             o_out_index, o_new_alpha);
                    fail_count <= fail_count + 1;
                end else begin
                    w = alpha_queue.pop_front();
                    if (w.tag !== o_out_index || w.alpha !== o_new_alpha) begin
                        $display("%0t: mismatch exp idx %h alpha %h, got idx %h alpha %h",
                                 $time, w.tag, w.alpha, o_out_index, o_new_alpha);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy) begin
                w.tag = i_particle_index;
                w.alpha = faded_alpha(i_disp_x, i_disp_y, i_disp_z);
                alpha_queue.push_back(w);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FADE_START:  fade_near  <= i_cfg_wdata;
                    CFG_FADE_END:    fade_far   <= i_cfg_wdata;
                    CFG_START_ALPHA: alpha_near <= i_cfg_wdata;
                    CFG_END_ALPHA:   alpha_far  <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;
    import daf_pkg::*;

    localparam int LATENCY = 39;
    localparam int CYCLE_LIMIT = 200000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [15:0]          i_particle_index = '0;
    logic [15:0]          i_disp_x = '0;
    logic [15:0]          i_disp_y = '0;
    logic [15:0]          i_disp_z = '0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [15:0]          i_cfg_wdata = '0;
    logic                 o_strobe;
    logic [15:0]          o_out_index;
    logic [15:0]          o_new_alpha;
    int                   fail_count;
    int                   pending_count;
    int                   cycle_count = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    distance_alpha_fade i_dut (.*);

    tb_alpha_checker i_checker (.*);

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[distance_alpha_fade] ERROR");
            $finish;
        end
    end

    // Present one word and hold it until the block takes it.
    task automatic send_particle(logic [15:0] tag, logic [15:0] dx, logic [15:0] dy,
                                 logic [15:0] dz);
        start            <= 1'b1;
        i_particle_index <= tag;
        i_disp_x         <= dx;
        i_disp_y         <= dy;
        i_disp_z         <= dz;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drop_start();
        start <= 1'b0;
    endtask

    // Drain the pipeline before touching the registers.
    task automatic wait_drained();
        drop_start();
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic load_fade(logic [15:0] s, logic [15:0] e, logic [15:0] a0,
                             logic [15:0] a1);
        write_reg(CFG_FADE_START, s);
        write_reg(CFG_FADE_END, e);
        write_reg(CFG_START_ALPHA, a0);
        write_reg(CFG_END_ALPHA, a1);
    endtask

    // Mostly short vectors that land near the fade window, some full-range.
    task automatic random_burst(int count, bit with_gaps);
        logic [15:0] v[3];
        int lim;
        for (int n = 0; n < count; n++) begin
            lim = $urandom_range(0, 3) == 0 ? 32767 : 4 << $urandom_range(0, 12);
            foreach (v[k]) begin
                if ($urandom_range(0, 9) == 0) v[k] = 16'($urandom);
                else v[k] = 16'($signed(int'($urandom_range(0, 2 * lim)) - lim));
            end
            send_particle(16'($urandom), v[0], v[1], v[2]);
            if (with_gaps && $urandom_range(0, 3) == 0) begin
                drop_start();
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes at reset settings.
        send_particle(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_particle(16'hFFFF, 16'h8000, 16'h8000, 16'h8000);
        send_particle(16'h5A5A, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_particle(16'hA5A5, 16'h7FFF, 16'h8000, 16'h0001);
        send_particle(16'h0001, 16'hFFFF, 16'h0000, 16'h0000);
        wait_drained();

        // Window with both edges hit exactly, falling alpha.
        load_fade(16'h0100, 16'h0400, 16'hFFFF, 16'h0000);
        send_particle(16'h0010, 16'h00FF, 16'h0000, 16'h0000);
        send_particle(16'h0011, 16'h0100, 16'h0000, 16'h0000);
        send_particle(16'h0012, 16'h0000, 16'hFD00, 16'h0000);
        send_particle(16'h0013, 16'h0000, 16'h0000, 16'h03FF);
        send_particle(16'h0014, 16'h0400, 16'h0000, 16'h0000);
        send_particle(16'h0015, 16'h0123, 16'hFEDC, 16'h0077);
        wait_drained();

        // Start not below end: interpolation unreachable.
        load_fade(16'h0300, 16'h0300, 16'h1234, 16'hFEDC);
        send_particle(16'h0020, 16'h02FF, 16'h0000, 16'h0000);
        send_particle(16'h0021, 16'h0300, 16'h0000, 16'h0000);
        wait_drained();
        write_reg(CFG_FADE_START, 16'hFFFF);
        write_reg(CFG_FADE_END, 16'h0000);
        send_particle(16'h0022, 16'h0000, 16'h0000, 16'h0000);
        send_particle(16'h0023, 16'h8000, 16'h0000, 16'h0000);
        wait_drained();

        // Out-of-range index must be ignored; rising alpha.
        load_fade(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        write_reg(3'd7, 16'h1111);
        write_reg(3'd4, 16'h2222);
        send_particle(16'h0030, 16'h7FFF, 16'h0000, 16'h0000);
        send_particle(16'h0031, 16'h0001, 16'h0000, 16'h0000);

        // Hold off until every expected word has come back.
        wait_drained();

        // Random phases, each with its own register setting.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: load_fade(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
                1: load_fade(16'h0200, 16'h2000, 16'h0000, 16'hFFFF);
                2: load_fade(16'h0000, 16'h0001, 16'h8000, 16'h7FFF);
                default: load_fade(16'($urandom_range(0, 16'h3000)),
                                   16'($urandom_range(16'h1000, 16'hC000)),
                                   16'($urandom), 16'($urandom));
            endcase
            random_burst(300, 1'b1);
            wait_drained();
        end
        // Last stretch streams back to back.
        random_burst(150, 1'b0);
        wait_drained();

        if (fail_count == 0) begin
            $display("[distance_alpha_fade] OK");
        end else begin
            $display("[distance_alpha_fade] ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/daf_pkg.sv
rtl/daf_front.sv
rtl/daf_queue.sv
rtl/daf_back.sv
rtl/distance_alpha_fade.sv
tb/tb_alpha_checker.sv
tb/tb_top.sv
